// ===== design/falb_pkg.sv =====
package falb_pkg;

	// fixed field widths
	localparam int ADDR_W = 20;
	localparam int LEN_W = 21;
	localparam int REQ_W = 21;
	localparam int NEED_W = 22;
	localparam int PAGES_W = 9;
	localparam int STATUS_W = 2;
	localparam int POLICY_W = 2;

	// defaults of the top-level parameters
	localparam int MAX_SEGMENTS_DEF = 64;
	localparam int PAGE_BYTES_DEF = 4096;
	localparam int HEADER_BYTES_DEF = 16;
	localparam int ALIGN_BYTES_DEF = 8;

	localparam int MIN_PAYLOAD = 8;
	localparam int MAX_REGION_PAGES = 256;
	localparam int ADDR_LIMIT = 1048576;

	// commands
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE = 1'b1;

	// fit policies
	localparam logic [POLICY_W-1:0] POL_BEST = 2'd0;
	localparam logic [POLICY_W-1:0] POL_WORST = 2'd1;
	localparam logic [POLICY_W-1:0] POL_FIRST = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd2;

	// classified command handed from front to back
	typedef struct packed {
		logic cmd;
		logic [POLICY_W-1:0] policy;
		logic [NEED_W-1:0] need;
		logic [ADDR_W-1:0] addr;
	} cmd_item_t;

	// one table entry, free segment or used block
	typedef struct packed {
		logic [ADDR_W-1:0] start;
		logic [LEN_W-1:0] len;
	} seg_t;

endpackage

// ===== design/falb_front.sv =====
module falb_front #(
	parameter int ALIGN_BYTES = falb_pkg::ALIGN_BYTES_DEF,
	parameter int HEADER_BYTES = falb_pkg::HEADER_BYTES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic in_cmd,
	input logic [falb_pkg::REQ_W-1:0] in_req,
	input logic [falb_pkg::POLICY_W-1:0] in_policy,
	input logic [falb_pkg::ADDR_W-1:0] in_addr,
	output logic push,
	input logic full,
	output falb_pkg::cmd_item_t push_item
);

	// reciprocal of the alignment, exact for every biased size below 2^NEED_W
	localparam int SH = falb_pkg::NEED_W + 7;
	localparam int MW = SH + 1;
	localparam int PW = falb_pkg::NEED_W + MW;
	localparam longint RECIP = ((longint'(1) << SH) + longint'(ALIGN_BYTES) - 1)
		/ longint'(ALIGN_BYTES);
	localparam logic [MW-1:0] RECIP_V = MW'(RECIP);
	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_DIV = 2'd1;
	localparam logic [1:0] F_PUSH = 2'd2;
	localparam logic [1:0] F_SCALE = 2'd3;

	logic [1:0] state_q;
	logic cmd_q;
	logic [falb_pkg::POLICY_W-1:0] policy_q;
	logic [falb_pkg::ADDR_W-1:0] addr_q;
	logic [falb_pkg::NEED_W-1:0] x_q;
	logic [falb_pkg::NEED_W-1:0] quo_q;
	logic [falb_pkg::NEED_W-1:0] req_ext;
	logic [PW-1:0] prod;

	assign in_ready = (state_q == F_IDLE);
	assign push = (state_q == F_PUSH) && !full;

	// minimum payload, then bias for rounding up
	always_comb begin
		req_ext = falb_pkg::NEED_W'(in_req);
		if (req_ext < falb_pkg::NEED_W'(falb_pkg::MIN_PAYLOAD))
			req_ext = falb_pkg::NEED_W'(falb_pkg::MIN_PAYLOAD);
		req_ext = req_ext + falb_pkg::NEED_W'(ALIGN_BYTES - 1);
	end

	// quotient by the alignment through the reciprocal
	assign prod = PW'(x_q) * PW'(RECIP_V);

	always_comb begin
		push_item.cmd = cmd_q;
		push_item.policy = policy_q;
		push_item.addr = addr_q;
		push_item.need = x_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (in_valid) begin
						if (in_cmd == falb_pkg::CMD_FREE)
							state_q <= F_PUSH;
						else
							state_q <= F_DIV;
					end
				end
				F_DIV: state_q <= F_SCALE;
				F_SCALE: state_q <= F_PUSH;
				F_PUSH: begin
					if (!full)
						state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// payload: capture, divide, then form the rounded size plus header
	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				cmd_q <= in_cmd;
				policy_q <= in_policy;
				addr_q <= in_addr;
				x_q <= req_ext;
			end
			F_DIV: begin
				quo_q <= prod[SH +: falb_pkg::NEED_W];
			end
			F_SCALE: begin
				x_q <= falb_pkg::NEED_W'(quo_q * falb_pkg::NEED_W'(ALIGN_BYTES))
					+ falb_pkg::NEED_W'(HEADER_BYTES);
			end
			default: ;
		endcase
	end

endmodule

// ===== design/falb_queue.sv =====
module falb_queue #(
	parameter int DEPTH = 4
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input falb_pkg::cmd_item_t push_item,
	output logic full,
	input logic pop,
	output logic not_empty,
	output falb_pkg::cmd_item_t pop_item
);

	localparam int PW = $clog2(DEPTH);

	falb_pkg::cmd_item_t slots_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [PW:0] cnt_q;

	assign full = (cnt_q == (PW+1)'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign pop_item = slots_q[rd_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	// item storage
	always_ff @(posedge clk) begin
		if (push)
			slots_q[wr_q] <= push_item;
	end

endmodule

// ===== design/falb_back.sv =====
module falb_back #(
	parameter int MAX_SEGMENTS = falb_pkg::MAX_SEGMENTS_DEF,
	parameter int PAGE_BYTES = falb_pkg::PAGE_BYTES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr,
	input logic [falb_pkg::PAGES_W-1:0] cfg_pages,
	input logic q_not_empty,
	input falb_pkg::cmd_item_t q_item,
	output logic q_pop,
	output logic out_valid,
	input logic out_ready,
	output logic [falb_pkg::STATUS_W-1:0] out_status,
	output logic [falb_pkg::ADDR_W-1:0] out_addr
);

	localparam int IW = $clog2(MAX_SEGMENTS);
	localparam int CW = $clog2(MAX_SEGMENTS + 1);
	localparam int PRW = falb_pkg::PAGES_W + $clog2(PAGE_BYTES + 1);
	localparam int AW = falb_pkg::ADDR_W;
	localparam int LW = falb_pkg::LEN_W;

	localparam logic [3:0] B_INIT0 = 4'd0;
	localparam logic [3:0] B_INIT1 = 4'd1;
	localparam logic [3:0] B_IDLE = 4'd2;
	localparam logic [3:0] B_ASLOT = 4'd3;
	localparam logic [3:0] B_ASCAN = 4'd4;
	localparam logic [3:0] B_AEND = 4'd5;
	localparam logic [3:0] B_USCAN = 4'd6;
	localparam logic [3:0] B_FSCAN = 4'd7;
	localparam logic [3:0] B_FDEC = 4'd8;
	localparam logic [3:0] B_SW_RD = 4'd9;
	localparam logic [3:0] B_SW_WR = 4'd10;
	localparam logic [3:0] B_DONE = 4'd11;

	logic [3:0] state_q;
	logic [falb_pkg::PAGES_W-1:0] pages_q;
	logic [LW-1:0] bytes_q;
	logic [CW-1:0] cnt_q;
	logic [MAX_SEGMENTS-1:0] uvalid_q;
	falb_pkg::cmd_item_t item_q;

	// tables
	falb_pkg::seg_t free_mem [MAX_SEGMENTS];
	falb_pkg::seg_t used_mem [MAX_SEGMENTS];
	falb_pkg::seg_t fr_q;
	falb_pkg::seg_t ur_q;
	logic [IW-1:0] fr_addr;
	logic fw_en;
	logic [IW-1:0] fw_addr;
	falb_pkg::seg_t fw_data;
	logic uw_en;

	// scan pipeline
	logic [CW-1:0] sc_q;
	logic [CW-1:0] sc_limit;
	logic sc_issue;
	logic vld_s1;
	logic [IW-1:0] idx_s1;

	// alloc bookkeeping
	logic [IW-1:0] slot_q;
	logic [IW-1:0] slot_c;
	logic slot_ok_c;
	logic found_q;
	logic [IW-1:0] pick_q;
	falb_pkg::seg_t pick_seg_q;
	logic fits;
	logic take;

	// free bookkeeping
	logic [IW-1:0] u_q;
	logic [LW-1:0] ulen_q;
	logic prev_ok_q;
	logic [IW-1:0] prev_q;
	falb_pkg::seg_t prev_seg_q;
	logic next_ok_q;
	logic [IW-1:0] next_q;
	logic [LW-1:0] next_len_q;
	logic [CW-1:0] pos_q;
	logic [LW:0] end_c;

	// sweep
	logic sw_ins_q;
	logic [CW-1:0] sw_i_q;
	falb_pkg::seg_t ins_seg_q;

	// result
	logic [falb_pkg::STATUS_W-1:0] res_status_q;
	logic [AW-1:0] res_addr_q;
	logic [PRW-1:0] prod;

	assign q_pop = (state_q == B_IDLE) && q_not_empty;
	assign prod = PRW'(pages_q) * PRW'(PAGE_BYTES);
	assign end_c = (LW+1)'(item_q.addr) + (LW+1)'(ulen_q);

	// lowest unused slot of the block table
	always_comb begin
		slot_c = '0;
		slot_ok_c = 1'b0;
		for (int i = MAX_SEGMENTS - 1; i >= 0; i--) begin
			if (!uvalid_q[i]) begin
				slot_c = IW'(i);
				slot_ok_c = 1'b1;
			end
		end
	end

	// scan issue and read address
	always_comb begin
		sc_limit = (state_q == B_USCAN) ? CW'(MAX_SEGMENTS) : cnt_q;
		sc_issue = ((state_q == B_ASCAN) || (state_q == B_USCAN) || (state_q == B_FSCAN))
			&& (sc_q < sc_limit);
		if (state_q == B_SW_RD) begin
			if (sw_ins_q)
				fr_addr = IW'(sw_i_q - 1'b1);
			else
				fr_addr = IW'(sw_i_q + 1'b1);
		end else begin
			fr_addr = sc_q[IW-1:0];
		end
	end

	// fit test of the segment read back
	always_comb begin
		fits = {1'b0, fr_q.len} >= item_q.need;
		take = 1'b0;
		case (item_q.policy)
			falb_pkg::POL_BEST: take = fits && (!found_q || fr_q.len < pick_seg_q.len);
			falb_pkg::POL_WORST: take = fits && (!found_q || fr_q.len > pick_seg_q.len);
			falb_pkg::POL_FIRST: take = fits && !found_q;
			default: take = 1'b0;
		endcase
	end

	// table writes
	always_comb begin
		fw_en = 1'b0;
		fw_addr = '0;
		fw_data = fr_q;
		uw_en = (state_q == B_AEND) && found_q;
		case (state_q)
			B_INIT1: begin
				fw_en = 1'b1;
				fw_data.start = '0;
				fw_data.len = bytes_q;
			end
			B_AEND: begin
				if (found_q && ({1'b0, pick_seg_q.len} > item_q.need)) begin
					fw_en = 1'b1;
					fw_addr = pick_q;
					fw_data.start = AW'(pick_seg_q.start + AW'(item_q.need));
					fw_data.len = LW'(pick_seg_q.len - LW'(item_q.need));
				end
			end
			B_FDEC: begin
				if (prev_ok_q) begin
					fw_en = 1'b1;
					fw_addr = prev_q;
					fw_data.start = prev_seg_q.start;
					fw_data.len = prev_seg_q.len + ulen_q
						+ (next_ok_q ? next_len_q : LW'(0));
				end else if (next_ok_q) begin
					fw_en = 1'b1;
					fw_addr = next_q;
					fw_data.start = item_q.addr;
					fw_data.len = next_len_q + ulen_q;
				end
			end
			B_SW_RD: begin
				if (sw_ins_q && !(sw_i_q > pos_q)) begin
					fw_en = 1'b1;
					fw_addr = pos_q[IW-1:0];
					fw_data = ins_seg_q;
				end
			end
			B_SW_WR: begin
				fw_en = 1'b1;
				fw_addr = sw_i_q[IW-1:0];
				fw_data = fr_q;
			end
			default: ;
		endcase
	end

	// memories with registered read data
	always_ff @(posedge clk) begin
		if (fw_en)
			free_mem[fw_addr] <= fw_data;
		fr_q <= free_mem[fr_addr];
	end

	always_ff @(posedge clk) begin
		if (uw_en)
			used_mem[slot_q] <= '{start: pick_seg_q.start, len: LW'(item_q.need)};
		ur_q <= used_mem[sc_q[IW-1:0]];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_INIT0;
			pages_q <= falb_pkg::PAGES_W'(1);
			cnt_q <= '0;
			uvalid_q <= '0;
			vld_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			vld_s1 <= sc_issue;
			if (out_valid && out_ready)
				out_valid <= 1'b0;
			if (cfg_wr) begin
				if (cfg_pages == '0)
					pages_q <= falb_pkg::PAGES_W'(1);
				else if (cfg_pages > falb_pkg::PAGES_W'(falb_pkg::MAX_REGION_PAGES))
					pages_q <= falb_pkg::PAGES_W'(falb_pkg::MAX_REGION_PAGES);
				else
					pages_q <= cfg_pages;
				state_q <= B_INIT0;
			end else begin
				case (state_q)
					B_INIT0: state_q <= B_INIT1;
					B_INIT1: begin
						cnt_q <= CW'(1);
						uvalid_q <= '0;
						state_q <= B_IDLE;
					end
					B_IDLE: begin
						if (q_not_empty)
							state_q <= (q_item.cmd == falb_pkg::CMD_FREE) ? B_USCAN : B_ASLOT;
					end
					B_ASLOT: begin
						if (!slot_ok_c)
							state_q <= B_DONE;
						else
							state_q <= B_ASCAN;
					end
					B_ASCAN: begin
						if (!sc_issue && !vld_s1)
							state_q <= B_AEND;
					end
					B_AEND: begin
						if (!found_q) begin
							state_q <= B_DONE;
						end else begin
							uvalid_q[slot_q] <= 1'b1;
							if ({1'b0, pick_seg_q.len} > item_q.need)
								state_q <= B_DONE;
							else
								state_q <= B_SW_RD;
						end
					end
					B_USCAN: begin
						if (!sc_issue && !vld_s1)
							state_q <= found_q ? B_FSCAN : B_DONE;
					end
					B_FSCAN: begin
						if (!sc_issue && !vld_s1)
							state_q <= B_FDEC;
					end
					B_FDEC: begin
						if (prev_ok_q && next_ok_q) begin
							uvalid_q[u_q] <= 1'b0;
							state_q <= B_SW_RD;
						end else if (prev_ok_q || next_ok_q) begin
							uvalid_q[u_q] <= 1'b0;
							state_q <= B_DONE;
						end else if (cnt_q >= CW'(MAX_SEGMENTS)) begin
							state_q <= B_DONE;
						end else begin
							uvalid_q[u_q] <= 1'b0;
							state_q <= B_SW_RD;
						end
					end
					B_SW_RD: begin
						if (sw_ins_q) begin
							if (sw_i_q > pos_q) begin
								state_q <= B_SW_WR;
							end else begin
								cnt_q <= cnt_q + 1'b1;
								state_q <= B_DONE;
							end
						end else begin
							if (CW'(sw_i_q + 1'b1) < cnt_q) begin
								state_q <= B_SW_WR;
							end else begin
								cnt_q <= cnt_q - 1'b1;
								state_q <= B_DONE;
							end
						end
					end
					B_SW_WR: state_q <= B_SW_RD;
					B_DONE: begin
						if (!out_valid || out_ready) begin
							out_valid <= 1'b1;
							state_q <= B_IDLE;
						end
					end
					default: state_q <= B_IDLE;
				endcase
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		idx_s1 <= sc_q[IW-1:0];
		if (sc_issue)
			sc_q <= sc_q + 1'b1;
		case (state_q)
			B_INIT0: begin
				if (prod > PRW'(falb_pkg::ADDR_LIMIT))
					bytes_q <= LW'(falb_pkg::ADDR_LIMIT);
				else
					bytes_q <= LW'(prod);
			end
			B_IDLE: begin
				item_q <= q_item;
				sc_q <= '0;
				found_q <= 1'b0;
				prev_ok_q <= 1'b0;
				next_ok_q <= 1'b0;
				pos_q <= '0;
				res_status_q <= falb_pkg::ST_OK;
				res_addr_q <= '0;
			end
			B_ASLOT: begin
				slot_q <= slot_c;
				if (!slot_ok_c)
					res_status_q <= falb_pkg::ST_NO_SPACE;
			end
			B_ASCAN: begin
				if (vld_s1 && take) begin
					found_q <= 1'b1;
					pick_q <= idx_s1;
					pick_seg_q <= fr_q;
				end
			end
			B_AEND: begin
				sw_ins_q <= 1'b0;
				sw_i_q <= CW'(pick_q);
				if (found_q)
					res_addr_q <= pick_seg_q.start;
				else
					res_status_q <= falb_pkg::ST_NO_SPACE;
			end
			B_USCAN: begin
				if (vld_s1 && !found_q && uvalid_q[idx_s1] && ur_q.start == item_q.addr) begin
					found_q <= 1'b1;
					u_q <= idx_s1;
					ulen_q <= ur_q.len;
				end
				if (!sc_issue && !vld_s1) begin
					sc_q <= '0;
					if (!found_q)
						res_status_q <= falb_pkg::ST_UNKNOWN;
				end
			end
			B_FSCAN: begin
				if (vld_s1) begin
					if ((LW+1)'(fr_q.start) + (LW+1)'(fr_q.len) == (LW+1)'(item_q.addr)) begin
						prev_ok_q <= 1'b1;
						prev_q <= idx_s1;
						prev_seg_q <= fr_q;
					end
					if ((LW+1)'(fr_q.start) == end_c) begin
						next_ok_q <= 1'b1;
						next_q <= idx_s1;
						next_len_q <= fr_q.len;
					end
					if (fr_q.start < item_q.addr)
						pos_q <= pos_q + 1'b1;
				end
			end
			B_FDEC: begin
				sw_ins_q <= !prev_ok_q && !next_ok_q;
				sw_i_q <= (!prev_ok_q && !next_ok_q) ? cnt_q : CW'(next_q);
				ins_seg_q <= '{start: item_q.addr, len: ulen_q};
				if (!prev_ok_q && !next_ok_q && cnt_q >= CW'(MAX_SEGMENTS))
					res_status_q <= falb_pkg::ST_NO_SPACE;
			end
			B_SW_WR: begin
				if (sw_ins_q)
					sw_i_q <= sw_i_q - 1'b1;
				else
					sw_i_q <= sw_i_q + 1'b1;
			end
			B_DONE: begin
				if (!out_valid || out_ready) begin
					out_status <= res_status_q;
					out_addr <= (res_status_q == falb_pkg::ST_OK) ? res_addr_q : '0;
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== design/free_list_block_allocator.sv =====
// free-list block allocator over a region of byte offsets
// s_axis carries commands: tuser bit 0 is the command (allocate or free),
// tuser bits 2:1 the fit policy, tdata the request size and block address.
// m_axis returns one result item per command: tuser holds the status,
// tdata the granted block offset (zero on failure and for every free).
// cfg_* writes the region size in pages and rebuilds both tables; write it
// only while no command is in flight.
// the front rounds the size of an allocate by a reciprocal multiplication and
// passes a free straight to the queue; the back then scans the free table one
// entry per cycle for an allocate, and for a free first the whole block table
// and then the free table, moving table entries when a segment is removed
// from or inserted into the table.
// front and back run independently through a four-deep command queue, so a
// new command is taken while the back works and while a result waits.
// reset gives one free segment of one page and an empty block table, set up
// in the states B_INIT0 and B_INIT1. a stalled m_axis holds its result and
// the back waits; commands keep queueing until the queue is full.
module free_list_block_allocator #(
	parameter int MAX_SEGMENTS = falb_pkg::MAX_SEGMENTS_DEF,
	parameter int PAGE_BYTES = falb_pkg::PAGE_BYTES_DEF,
	parameter int HEADER_BYTES = falb_pkg::HEADER_BYTES_DEF,
	parameter int ALIGN_BYTES = falb_pkg::ALIGN_BYTES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [47:0] s_axis_tdata, // request_bytes[20:0], block_address[40:21], zero pad
	input logic [2:0] s_axis_tuser, // command[0], fit_policy[2:1]
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [23:0] m_axis_tdata, // granted_address[19:0], zero pad
	output logic [1:0] m_axis_tuser, // status[1:0]
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [8:0] cfg_data // region_pages
);

	falb_pkg::cmd_item_t push_item;
	falb_pkg::cmd_item_t pop_item;
	logic push;
	logic full;
	logic pop;
	logic not_empty;
	logic [falb_pkg::ADDR_W-1:0] out_addr;

	assign cfg_ready = 1'b1;
	assign m_axis_tdata = {4'd0, out_addr};

	// command intake and size rounding
	falb_front #(
		.ALIGN_BYTES(ALIGN_BYTES),
		.HEADER_BYTES(HEADER_BYTES)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_cmd(s_axis_tuser[0]),
		.in_req(s_axis_tdata[20:0]),
		.in_policy(s_axis_tuser[2:1]),
		.in_addr(s_axis_tdata[40:21]),
		.push(push),
		.full(full),
		.push_item(push_item)
	);

	// decoupling queue
	falb_queue #(
		.DEPTH(4)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_item(push_item),
		.full(full),
		.pop(pop),
		.not_empty(not_empty),
		.pop_item(pop_item)
	);

	// table engine
	falb_back #(
		.MAX_SEGMENTS(MAX_SEGMENTS),
		.PAGE_BYTES(PAGE_BYTES)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr(cfg_valid && cfg_ready),
		.cfg_pages(cfg_data),
		.q_not_empty(not_empty),
		.q_item(pop_item),
		.q_pop(pop),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_status(m_axis_tuser),
		.out_addr(out_addr)
	);

endmodule

// ===== design/falb_checker.sv =====
module falb_checker (
	input logic clk,
	input logic arst_n,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic [1:0] m_axis_tuser
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tuser)
		&& $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// status is one of the defined codes
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser == falb_pkg::ST_OK)
		|| (m_axis_tuser == falb_pkg::ST_NO_SPACE) || (m_axis_tuser == falb_pkg::ST_UNKNOWN))
		else $error("undefined status");

	// a failed command grants nothing
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != falb_pkg::ST_OK) |-> (m_axis_tdata == 24'd0))
		else $error("address on failure");

endmodule

bind free_list_block_allocator falb_checker u_checker (
	.clk(clk),
	.arst_n(arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata),
	.m_axis_tuser(m_axis_tuser)
);

// ===== verif/tb_free_list_block_allocator.sv =====
`timescale 1ns / 100ps

module tb_free_list_block_allocator;
	import falb_pkg::*;

	localparam int SEGS = MAX_SEGMENTS_DEF;
	localparam int HDR = HEADER_BYTES_DEF;
	localparam int ALN = ALIGN_BYTES_DEF;
	localparam int SETTLE = 2 * SEGS * 3 + 100;
	// policy code outside the defined set
	localparam logic [POLICY_W-1:0] POL_BAD = 2'd3;

	// one command row of the directed table
	typedef struct {
		logic cmd;
		logic [REQ_W-1:0] req;
		logic [POLICY_W-1:0] pol;
		logic [ADDR_W-1:0] addr;
		bit typed;
		logic [STATUS_W-1:0] st;
		logic [ADDR_W-1:0] ga;
	} cmd_row_t;

	typedef struct {
		logic [STATUS_W-1:0] st;
		logic [ADDR_W-1:0] ga;
	} grant_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [47:0] s_axis_tdata;
	logic [2:0] s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [23:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;
	logic cfg_valid;
	logic cfg_ready;
	logic [8:0] cfg_data;

	// mirror of the allocator tables
	logic [ADDR_W-1:0] fr_start[SEGS];
	logic [LEN_W-1:0] fr_len[SEGS];
	logic [6:0] fr_count;
	logic [ADDR_W-1:0] blk_start[SEGS];
	logic [NEED_W-1:0] blk_len[SEGS];
	logic blk_live[SEGS];
	logic [LEN_W-1:0] region_bytes;

	grant_t grant_q[$];
	logic [ADDR_W-1:0] live_q[$];
	cmd_row_t dir_tab[13];
	int errors = 0;
	int snd_idle = 0;
	int rcv_idle = 0;

	free_list_block_allocator dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("tb_free_list_block_allocator: done, errors");
		$finish;
	end

	// rebuild tables for a region size write
	function automatic void tables_init(logic [8:0] pages);
		logic [31:0] p;
		logic [31:0] bytes;
		p = 32'(pages);
		if (p < 1) p = 1;
		if (p > MAX_REGION_PAGES) p = MAX_REGION_PAGES;
		bytes = p * PAGE_BYTES_DEF;
		if (bytes > ADDR_LIMIT) bytes = ADDR_LIMIT;
		region_bytes = bytes[LEN_W-1:0];
		for (int i = 0; i < SEGS; i++) begin
			fr_start[i] = '0;
			fr_len[i] = '0;
			blk_live[i] = 1'b0;
			blk_start[i] = '0;
			blk_len[i] = '0;
		end
		fr_len[0] = region_bytes;
		fr_count = 7'd1;
	endfunction

	function automatic void seg_remove(int k);
		for (int i = k; i + 1 < fr_count; i++) begin
			fr_start[i] = fr_start[i+1];
			fr_len[i] = fr_len[i+1];
		end
		fr_count--;
	endfunction

	// place a block by fit policy
	function automatic logic [STATUS_W-1:0] place_block(logic [REQ_W-1:0] req,
			logic [POLICY_W-1:0] pol, output logic [ADDR_W-1:0] ga);
		logic [NEED_W-1:0] need;
		logic [NEED_W-1:0] r;
		logic [LEN_W-1:0] best;
		int slot;
		int pick;
		r = NEED_W'(req);
		ga = '0;
		best = '0;
		slot = -1;
		pick = -1;
		if (r < NEED_W'(MIN_PAYLOAD)) r = NEED_W'(MIN_PAYLOAD);
		need = NEED_W'((r + ALN - 1) / ALN * ALN + HDR);
		for (int i = 0; i < SEGS; i++)
			if (!blk_live[i] && slot < 0) slot = i;
		if (slot < 0) return ST_NO_SPACE;
		for (int i = 0; i < fr_count; i++) begin
			if (NEED_W'(fr_len[i]) >= need) begin
				if (pol == POL_BEST) begin
					if (pick < 0 || fr_len[i] < best) begin pick = i; best = fr_len[i]; end
				end else if (pol == POL_WORST) begin
					if (pick < 0 || fr_len[i] > best) begin pick = i; best = fr_len[i]; end
				end else if (pol == POL_FIRST) begin
					if (pick < 0) pick = i;
				end
			end
		end
		if (pick < 0) return ST_NO_SPACE;
		ga = fr_start[pick];
		blk_live[slot] = 1'b1;
		blk_start[slot] = fr_start[pick];
		blk_len[slot] = need;
		if (NEED_W'(fr_len[pick]) > need) begin
			fr_start[pick] = ADDR_W'(NEED_W'(fr_start[pick]) + need);
			fr_len[pick] = LEN_W'(NEED_W'(fr_len[pick]) - need);
		end else begin
			seg_remove(pick);
		end
		return ST_OK;
	endfunction

	// return a block and merge with adjacent free segments
	function automatic logic [STATUS_W-1:0] release_block(logic [ADDR_W-1:0] a);
		int u;
		int prv;
		int nxt;
		int pos;
		logic [NEED_W-1:0] len;
		logic [NEED_W:0] fin;
		u = -1;
		prv = -1;
		nxt = -1;
		for (int i = 0; i < SEGS; i++)
			if (u < 0 && blk_live[i] && blk_start[i] == a) u = i;
		if (u < 0) return ST_UNKNOWN;
		len = blk_len[u];
		fin = (NEED_W+1)'(a) + (NEED_W+1)'(len);
		for (int i = 0; i < fr_count; i++) begin
			if ((NEED_W+1)'(fr_start[i]) + (NEED_W+1)'(fr_len[i]) == (NEED_W+1)'(a))
				prv = i;
			if ((NEED_W+1)'(fr_start[i]) == fin) nxt = i;
		end
		if (prv >= 0 && nxt >= 0) begin
			fr_len[prv] = LEN_W'(NEED_W'(fr_len[prv]) + len + NEED_W'(fr_len[nxt]));
			seg_remove(nxt);
		end else if (prv >= 0) begin
			fr_len[prv] = LEN_W'(NEED_W'(fr_len[prv]) + len);
		end else if (nxt >= 0) begin
			fr_start[nxt] = a;
			fr_len[nxt] = LEN_W'(NEED_W'(fr_len[nxt]) + len);
		end else begin
			if (fr_count >= SEGS) return ST_NO_SPACE;
			pos = 0;
			while (pos < fr_count && fr_start[pos] < a) pos++;
			for (int i = fr_count; i > pos; i--) begin
				fr_start[i] = fr_start[i-1];
				fr_len[i] = fr_len[i-1];
			end
			fr_start[pos] = a;
			fr_len[pos] = LEN_W'(len);
			fr_count++;
		end
		blk_live[u] = 1'b0;
		return ST_OK;
	endfunction

	// predict one command and keep the list of live blocks current
	function automatic grant_t grant_predict(logic cmd, logic [REQ_W-1:0] req,
			logic [POLICY_W-1:0] pol, logic [ADDR_W-1:0] a);
		grant_t g;
		logic [ADDR_W-1:0] ga;
		ga = '0;
		if (cmd == CMD_ALLOC) begin
			g.st = place_block(req, pol, ga);
			if (g.st == ST_OK) live_q.push_back(ga);
		end else begin
			g.st = release_block(a);
			if (g.st == ST_OK)
				for (int i = 0; i < live_q.size(); i++)
					if (live_q[i] == a) begin live_q.delete(i); break; end
		end
		g.ga = (g.st == ST_OK) ? ga : '0;
		return g;
	endfunction

	task automatic send_cmd(logic cmd, logic [REQ_W-1:0] req, logic [POLICY_W-1:0] pol,
			logic [ADDR_W-1:0] a, bit typed = 0, logic [STATUS_W-1:0] st = ST_OK,
			logic [ADDR_W-1:0] ga = '0);
		grant_t g;
		while ($urandom_range(0, 99) < snd_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {7'd0, a, req};
		s_axis_tuser <= {pol, cmd};
		do @(posedge clk); while (!s_axis_tready);
		g = grant_predict(cmd, req, pol, a);
		if (typed) begin
			g.st = st;
			g.ga = ga;
		end
		grant_q.push_back(g);
	endtask

	task automatic drain_pause();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (grant_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_region(logic [8:0] pages);
		drain_pause();
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= pages;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		tables_init(pages);
	endtask

	// receiver stalls
	always @(posedge clk)
		m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle);

	// compare each result item with the oldest prediction
	always @(posedge clk) begin
		grant_t g;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (grant_q.size() == 0) begin
				$error("result item with nothing pending: status %0d addr %0h",
					m_axis_tuser, m_axis_tdata[19:0]);
				errors++;
			end else begin
				g = grant_q.pop_front();
				if (m_axis_tuser !== g.st) begin
					$error("status: expected %0d, got %0d", g.st, m_axis_tuser);
					errors++;
				end
				if (m_axis_tdata[19:0] !== g.ga) begin
					$error("granted_address: expected %0h, got %0h", g.ga,
						m_axis_tdata[19:0]);
					errors++;
				end
			end
		end
	end

	initial begin
		logic [8:0] phase_pages[6];
		int r;
		logic cmd;
		logic [REQ_W-1:0] req;
		logic [POLICY_W-1:0] pol;
		logic [ADDR_W-1:0] a;
		phase_pages = '{9'd0, 9'd256, 9'd511, 9'd300, 9'd17, 9'd2};

		// alloc and free on a one-page region, then errors and merges
		dir_tab[0] = '{CMD_ALLOC, 21'd0, POL_BEST, 20'hFFFFF, 1, ST_OK, 20'd0};
		dir_tab[1] = '{CMD_ALLOC, 21'd8, POL_FIRST, 20'd0, 1, ST_OK, 20'd24};
		dir_tab[2] = '{CMD_ALLOC, 21'd9, POL_WORST, 20'd0, 1, ST_OK, 20'd48};
		dir_tab[3] = '{CMD_ALLOC, 21'd8, POL_BAD, 20'd0, 1, ST_NO_SPACE, 20'd0};
		dir_tab[4] = '{CMD_ALLOC, 21'h1FFFFF, POL_FIRST, 20'd0, 1, ST_NO_SPACE, 20'd0};
		dir_tab[5] = '{CMD_FREE, 21'h1FFFFF, POL_BAD, 20'hFFFFF, 1, ST_UNKNOWN, 20'd0};
		dir_tab[6] = '{CMD_FREE, 21'd0, POL_BEST, 20'd24, 1, ST_OK, 20'd0};
		dir_tab[7] = '{CMD_FREE, 21'd0, POL_BEST, 20'd0, 1, ST_OK, 20'd0};
		dir_tab[8] = '{CMD_ALLOC, 21'd4080, POL_BEST, 20'd0, 1, ST_NO_SPACE, 20'd0};
		dir_tab[9] = '{CMD_FREE, 21'd0, POL_BEST, 20'd48, 1, ST_OK, 20'd0};
		dir_tab[10] = '{CMD_ALLOC, 21'd4080, POL_FIRST, 20'd0, 1, ST_OK, 20'd0};
		dir_tab[11] = '{CMD_ALLOC, 21'd0, POL_BEST, 20'd0, 1, ST_NO_SPACE, 20'd0};
		dir_tab[12] = '{CMD_FREE, 21'd0, POL_WORST, 20'd0, 1, ST_OK, 20'd0};

		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		tables_init(9'd1);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (4) @(posedge clk);

		snd_idle = 14;
		rcv_idle = 86;
		foreach (dir_tab[i])
			send_cmd(dir_tab[i].cmd, dir_tab[i].req, dir_tab[i].pol, dir_tab[i].addr,
				dir_tab[i].typed, dir_tab[i].st, dir_tab[i].ga);

		// fill the block table past its end, then return every block
		for (int i = 0; i <= SEGS; i++)
			send_cmd(CMD_ALLOC, 21'd0, POL_FIRST, 20'd0);
		while (live_q.size() != 0)
			send_cmd(CMD_FREE, 21'd0, POL_BEST, live_q[$urandom_range(0, live_q.size() - 1)]);

		for (int ph = 0; ph < 6; ph++) begin
			write_region(phase_pages[ph]);
			if (ph == 2) begin snd_idle = 86; rcv_idle = 14; end
			if (ph == 4) begin snd_idle = 0; rcv_idle = 0; end
			for (int n = 0; n < 300; n++) begin
				if (n == 150) drain_pause();
				r = $urandom_range(0, 99);
				req = REQ_W'($urandom);
				pol = POLICY_W'($urandom);
				a = ADDR_W'($urandom);
				if (r < 48 || live_q.size() == 0) begin
					cmd = CMD_ALLOC;
					r = $urandom_range(0, 99);
					if (r < 85) req = REQ_W'($urandom_range(0, 300));
					else if (r < 95) req = REQ_W'($urandom_range(0, region_bytes));
					pol = ($urandom_range(0, 99) < 5) ? POL_BAD
						: POLICY_W'($urandom_range(0, 2));
				end else begin
					cmd = CMD_FREE;
					if (r < 88) a = live_q[$urandom_range(0, live_q.size() - 1)];
					else if (r < 94) a = ADDR_W'(live_q[0] + ADDR_W'(8));
				end
				send_cmd(cmd, req, pol, a);
			end
		end

		drain_pause();
		repeat (SETTLE) @(posedge clk);
		if (errors == 0)
			$display("tb_free_list_block_allocator: done, clean");
		else
			$display("tb_free_list_block_allocator: done, errors");
		$finish;
	end

endmodule
